// ===== hw/rtl/ood_pkg.sv =====
package ood_pkg;

  localparam int FREQ_BITS = 27;
  localparam int QUO_BITS = 12;
  localparam int DIV_W = FREQ_BITS + QUO_BITS;
  localparam int DIV_STEPS = QUO_BITS;
  localparam int OCT_COUNT = 15;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [FREQ_BITS-1:0] FREQ_MIN = FREQ_BITS'(32'd1039);
  localparam logic [FREQ_BITS-1:0] FREQ_LIMIT = FREQ_BITS'(32'd68030000);
  localparam logic [11:0] DAC_SCALE = 12'd2078;
  localparam int DAC_SHIFT = 10;
  localparam logic [QUO_BITS-1:0] DAC_BASE = QUO_BITS'(2048);
  localparam logic [QUO_BITS-1:0] DAC_SAT_HI = QUO_BITS'(1025);
  localparam logic [9:0] DAC_MAX = 10'd1023;

  localparam logic [FREQ_BITS-1:0] OCT_EDGES [OCT_COUNT] = '{
    FREQ_BITS'(32'd2076), FREQ_BITS'(32'd4152), FREQ_BITS'(32'd8304),
    FREQ_BITS'(32'd16610), FREQ_BITS'(32'd33220), FREQ_BITS'(32'd66430),
    FREQ_BITS'(32'd132900), FREQ_BITS'(32'd265700), FREQ_BITS'(32'd531400),
    FREQ_BITS'(32'd1063000), FREQ_BITS'(32'd2126000), FREQ_BITS'(32'd4252000),
    FREQ_BITS'(32'd8503000), FREQ_BITS'(32'd17010000), FREQ_BITS'(32'd34010000)
  };

  typedef struct packed {
    logic [FREQ_BITS-1:0] freq_hz;
    logic [1:0]           output_mode;
  } request_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  octave;
    logic [9:0]  dac_value;
    logic [15:0] control_word;
  } result_t;

  typedef struct packed {
    logic                 err;
    logic [3:0]           octave;
    logic [1:0]           mode;
    logic [FREQ_BITS-1:0] freq;
    logic [DIV_W-1:0]     num;
  } class_t;

  typedef struct packed {
    logic                 err;
    logic [3:0]           octave;
    logic [1:0]           mode;
    logic [FREQ_BITS-1:0] freq;
    logic [DIV_W-1:0]     rem;
    logic [QUO_BITS-1:0]  quo;
  } div_t;

  function automatic class_t classify(request_t r);
    class_t c;
    c.err = (r.freq_hz < FREQ_MIN) || (r.freq_hz >= FREQ_LIMIT);
    c.octave = 4'd0;
    for (int i = 0; i < OCT_COUNT; i++) begin
      if (r.freq_hz >= OCT_EDGES[i]) begin
        c.octave = 4'(i + 1);
      end
    end
    c.mode = r.output_mode;
    c.freq = r.freq_hz;
    // ceil division done as floor of (num + f - 1) / f
    c.num = (DIV_W'(DAC_SCALE) << (DAC_SHIFT + int'(c.octave)))
            + DIV_W'(r.freq_hz) - DIV_W'(1);
    return c;
  endfunction

  function automatic result_t pack_result(div_t s);
    result_t r;
    logic [QUO_BITS-1:0] v;
    r = '0;
    v = DAC_BASE - s.quo;
    r.status = s.err;
    if (!s.err) begin
      r.octave = s.octave;
      if (s.quo >= DAC_BASE) begin
        r.dac_value = 10'd0;
      end else if (s.quo < DAC_SAT_HI) begin
        r.dac_value = DAC_MAX;
      end else begin
        r.dac_value = v[9:0];
      end
      r.control_word = {r.octave, r.dac_value, s.mode};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/oscillator_octave_dac_word.sv =====
// oscillator octave and dac control word
// input channel: a request word (freq_hz, output_mode) is taken on push when
//   full is low
// result channel: the oldest result word (status, octave, dac_value,
//   control_word) is shown while empty is low and leaves on pop
// one result word per request word, in request order
// the front stage range checks the frequency, picks the octave and builds
//   the rounded-up numerator; a four-word queue follows
// the back part is a twelve-stage restoring divider, one quotient bit per
//   stage, then the saturating dac logic feeding the output register
// throughput: one word per cycle while pop keeps up, limited by one divider stage per cycle
// when pop stays low with a result shown the back part holds, the queue fills, then the front
//   stage holds and full goes high; nothing is dropped
// out of range frequencies give status 1 and zero octave, dac and word
// reset (rst, synchronous) empties every stage and the queue
module oscillator_octave_dac_word (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ood_pkg::request_t request,
  output logic              empty,
  input  logic              pop,
  output ood_pkg::result_t  result
);

  logic            q_full;
  logic            q_empty;
  logic            q_rd;
  logic            fwd_valid;
  ood_pkg::class_t fwd;
  ood_pkg::class_t q_rdata;

  ood_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .q_full    (q_full),
    .fwd_valid (fwd_valid),
    .fwd       (fwd)
  );

  ood_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (fwd_valid),
    .wdata   (fwd),
    .q_full  (q_full),
    .rd      (q_rd),
    .q_empty (q_empty),
    .rdata   (q_rdata)
  );

  ood_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== hw/rtl/ood_front.sv =====
module ood_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ood_pkg::request_t request,
  input  logic              q_full,
  output logic              fwd_valid,
  output ood_pkg::class_t   fwd
);

  logic            fv;
  ood_pkg::class_t fdata;
  logic            load;

  assign full = fv && q_full;
  assign load = push && !full;
  assign fwd_valid = fv;
  assign fwd = fdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (load) begin
      fv <= 1'b1;
    end else if (!q_full) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fdata <= ood_pkg::classify(request);
    end
  end

endmodule

// ===== hw/rtl/ood_queue.sv =====
module ood_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  ood_pkg::class_t wdata,
  output logic            q_full,
  input  logic            rd,
  output logic            q_empty,
  output ood_pkg::class_t rdata
);

  ood_pkg::class_t              mem [ood_pkg::QUEUE_DEPTH];
  logic [ood_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [ood_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [ood_pkg::QUEUE_AW:0]   count;
  logic                         do_wr;
  logic                         do_rd;

  assign q_full = (count == (ood_pkg::QUEUE_AW + 1)'(ood_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr = wr && !q_full;
  assign do_rd = rd && !q_empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/ood_back.sv =====
module ood_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  ood_pkg::class_t  q_rdata,
  output logic             q_rd,
  input  logic             pop,
  output logic             empty,
  output ood_pkg::result_t result
);

  logic                    en;
  logic                    ov;
  ood_pkg::result_t        odata;
  logic                    sv [ood_pkg::DIV_STEPS+1];
  ood_pkg::div_t           sd [ood_pkg::DIV_STEPS+1];

  assign en = !ov || pop;
  assign q_rd = en && !q_empty;
  assign empty = !ov;
  assign result = odata;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      sd[0].err <= q_rdata.err;
      sd[0].octave <= q_rdata.octave;
      sd[0].mode <= q_rdata.mode;
      sd[0].freq <= q_rdata.freq;
      sd[0].rem <= q_rdata.num;
      sd[0].quo <= '0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < ood_pkg::DIV_STEPS; j++) begin : g_step
    localparam int SH = ood_pkg::DIV_STEPS - 1 - j;
    logic [ood_pkg::DIV_W-1:0] dv;
    logic                      take;

    assign dv = ood_pkg::DIV_W'(sd[j].freq) << SH;
    assign take = (sd[j].rem >= dv);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (en) begin
        sv[j+1] <= sv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[j+1].err <= sd[j].err;
        sd[j+1].octave <= sd[j].octave;
        sd[j+1].mode <= sd[j].mode;
        sd[j+1].freq <= sd[j].freq;
        sd[j+1].rem <= take ? (sd[j].rem - dv) : sd[j].rem;
        sd[j+1].quo <= {sd[j].quo[ood_pkg::QUO_BITS-2:0], take};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= sv[ood_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      odata <= ood_pkg::pack_result(sd[ood_pkg::DIV_STEPS]);
    end
  end

endmodule

// ===== verif/oscillator_octave_dac_word_chk.sv =====
module oscillator_octave_dac_word_chk (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  ood_pkg::request_t request,
  input  logic              empty,
  input  logic              pop,
  input  ood_pkg::result_t  result,
  output int                mismatches,
  output int                waiting,
  output int                range_errors,
  output int                dac_floors,
  output int                dac_ceilings
);
  import ood_pkg::*;

  localparam int unsigned LOW_HZ  = 1039;
  localparam int unsigned HIGH_HZ = 68030000;

  result_t expected_words[$];
  result_t exp_w;

  initial begin
    mismatches   = 0;
    waiting      = 0;
    range_errors = 0;
    dac_floors   = 0;
    dac_ceilings = 0;
  end

  function automatic int unsigned threshold_hz(input int i);
    case (i)
      0:       threshold_hz = 2076;
      1:       threshold_hz = 4152;
      2:       threshold_hz = 8304;
      3:       threshold_hz = 16610;
      4:       threshold_hz = 33220;
      5:       threshold_hz = 66430;
      6:       threshold_hz = 132900;
      7:       threshold_hz = 265700;
      8:       threshold_hz = 531400;
      9:       threshold_hz = 1063000;
      10:      threshold_hz = 2126000;
      11:      threshold_hz = 4252000;
      12:      threshold_hz = 8503000;
      13:      threshold_hz = 17010000;
      default: threshold_hz = 34010000;
    endcase
  endfunction

  // octave from thresholds, then dac = 2048 - ceil(2078 * 2^(10 + octave) / f), clipped to 0..1023
  function automatic result_t predict_word(input request_t w);
    result_t     r;
    logic [63:0] f;
    logic [63:0] num;
    logic [63:0] quo;
    logic [3:0]  oct;
    logic [9:0]  dac;
    r = '0;
    f = 64'(w.freq_hz);
    if (f < 64'(LOW_HZ) || f >= 64'(HIGH_HZ)) begin
      r.status = 1'b1;
    end else begin
      oct = 4'd0;
      for (int i = 0; i < 15; i++) begin
        if (f >= 64'(threshold_hz(i))) begin
          oct = 4'(i + 1);
        end
      end
      num = 64'd2078 << (10 + int'(oct));
      quo = (num + f - 64'd1) / f;
      if (quo >= 64'd2048) begin
        dac = 10'd0;
      end else if (64'd2048 - quo > 64'd1023) begin
        dac = 10'd1023;
      end else begin
        dac = 10'(64'd2048 - quo);
      end
      r.octave       = oct;
      r.dac_value    = dac;
      r.control_word = {oct, dac, w.output_mode};
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        exp_w = predict_word(request);
        if (exp_w.status) begin
          range_errors++;
        end else if (exp_w.dac_value == 10'd0) begin
          dac_floors++;
        end else if (exp_w.dac_value == 10'd1023) begin
          dac_ceilings++;
        end
        expected_words.push_back(exp_w);
      end
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result word %h", result);
          end
        end else begin
          exp_w = expected_words.pop_front();
          if (result.status !== exp_w.status || result.octave !== exp_w.octave ||
              result.dac_value !== exp_w.dac_value ||
              result.control_word !== exp_w.control_word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: status %b/%b octave %0d/%0d dac %0d/%0d word %h/%h",
                       exp_w.status, result.status, exp_w.octave, result.octave,
                       exp_w.dac_value, result.dac_value,
                       exp_w.control_word, result.control_word);
            end
          end
        end
      end
      waiting = expected_words.size();
    end
  end

endmodule

// ===== verif/oscillator_octave_dac_word_tb.sv =====
module oscillator_octave_dac_word_tb;
  import ood_pkg::*;

  localparam int RANDOM_WORDS = 1550;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 48;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  request_t request = '0;
  logic     full;
  logic     empty;
  result_t  result;

  int mismatches;
  int waiting;
  int range_errors;
  int dac_floors;
  int dac_ceilings;
  int idle_cycles = 0;
  int total_words;
  request_t directed[$];

  oscillator_octave_dac_word u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  oscillator_octave_dac_word_chk u_chk (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .request      (request),
    .empty        (empty),
    .pop          (pop),
    .result       (result),
    .mismatches   (mismatches),
    .waiting      (waiting),
    .range_errors (range_errors),
    .dac_floors   (dac_floors),
    .dac_ceilings (dac_ceilings)
  );

  initial begin
    forever begin
      #2 clk = ~clk;
    end
  end

  function automatic request_t make_word(input int unsigned f, input int unsigned m);
    request_t w;
    w.freq_hz     = FREQ_BITS'(f);
    w.output_mode = 2'(m);
    return w;
  endfunction

  function automatic int unsigned band_edge(input int i);
    if (i < 0) begin
      band_edge = 1039;
    end else if (i >= OCT_COUNT) begin
      band_edge = 68030000;
    end else begin
      band_edge = int'(OCT_EDGES[i]);
    end
  endfunction

  // mostly in-range words spread over the octave bands and their edges
  function automatic request_t random_request();
    int unsigned sel;
    int          o;
    int unsigned f;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      f = $urandom;
    end else if (sel < 12) begin
      f = $urandom_range(0, 1038);
    end else if (sel < 16) begin
      f = $urandom_range(68030000, 134217727);
    end else if (sel < 32) begin
      o = $urandom_range(0, OCT_COUNT + 1) - 1;
      f = band_edge(o) + $urandom_range(0, 6) - 3;
    end else begin
      o = $urandom_range(0, 15);
      f = $urandom_range(band_edge(o - 1), band_edge(o) - 1);
    end
    return make_word(f, $urandom_range(0, 3));
  endfunction

  function automatic int unsigned draw_gap(input int style);
    if (style == 0) begin
      draw_gap = $urandom_range(0, 13);
    end else if (style == 1) begin
      draw_gap = 0;
    end else begin
      draw_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    directed.push_back(make_word(0, 0));
    directed.push_back(make_word(1038, 1));
    directed.push_back(make_word(1039, 2));
    directed.push_back(make_word(2075, 3));
    directed.push_back(make_word(2076, 0));
    directed.push_back(make_word(4151, 1));
    directed.push_back(make_word(4152, 2));
    directed.push_back(make_word(265699, 3));
    directed.push_back(make_word(1062999, 0));
    directed.push_back(make_word(1063000, 1));
    directed.push_back(make_word(2125999, 2));
    directed.push_back(make_word(2126000, 3));
    directed.push_back(make_word(17009999, 0));
    directed.push_back(make_word(34009999, 1));
    directed.push_back(make_word(34010000, 2));
    directed.push_back(make_word(68029999, 3));
    directed.push_back(make_word(68030000, 0));
    directed.push_back(make_word(134217727, 3));
    directed.push_back(make_word(67108864, 1));
    directed.push_back(make_word(1500, 2));
    directed.push_back(make_word(50000000, 3));
    total_words = directed.size() + RANDOM_WORDS;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    fork
      begin : feed
        int          style;
        int unsigned gap;
        request_t    w;
        style = 0;
        for (int i = 0; i < total_words; i++) begin
          if (i % 200 == 0) begin
            style = $urandom_range(0, 2);
          end
          w = (i < directed.size()) ? directed[i] : random_request();
          gap = draw_gap(style);
          if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          push    <= 1'b1;
          request <= w;
          @(posedge clk);
          while (full) @(posedge clk);
        end
        push <= 1'b0;
      end
      begin : drain
        int          style;
        int unsigned gap;
        style = 0;
        for (int i = 0; i < total_words; i++) begin
          if (i % 170 == 0) begin
            style = $urandom_range(0, 2);
          end
          gap = draw_gap(style);
          if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          pop <= 1'b1;
          @(posedge clk);
          while (empty) @(posedge clk);
        end
        // pop stays high so any extra word is caught
      end
    join

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d request words, %0d directed, rest random with varied gaps",
             total_words, directed.size());
    $display("out of range %0d, dac floor %0d, dac ceiling %0d, mismatches %0d",
             range_errors, dac_floors, dac_ceilings, mismatches);
    if (mismatches == 0 && waiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
